@@ hdl/crsf_channel_frame_decoder_top_assert.svh @@
// Assertion macros shared by the channel frame decoder modules.
// Expects signals named clock and reset in the module that uses them.
`ifndef CRSF_CHANNEL_FRAME_DECODER_TOP_ASSERT_SVH
`define CRSF_CHANNEL_FRAME_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define CRSFD_CHECK_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("crsfd same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define CRSFD_CHECK_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("crsfd next-cycle check failed");

`endif

@@ hdl/crsfd_pkg.sv @@
// Shared types, constants and the CRC-8 step function for the channel frame decoder.
// No dependencies.
`default_nettype none

package crsfd_pkg;

   localparam int NUM_CHANNELS  = 5;
   localparam int MAX_FRAME_LEN = 62;
   localparam int OUT_CHANNELS  = 5;
   localparam int HEAD_DEPTH    = 8;
   localparam int HEAD_IDX_W    = $clog2(HEAD_DEPTH);
   localparam int CHAN_W        = 11;
   localparam int GAP_W         = 16;
   localparam int LEN_W         = 6;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 16;

   localparam logic [7:0] SYNC_BYTE = 8'hC8;
   localparam logic [7:0] CRC_POLY  = 8'hD5;

   localparam logic [7:0]        RESET_FRAME_TYPE = 8'd22;
   localparam logic [CHAN_W-1:0] RESET_VALID_MIN  = 11'd172;
   localparam logic [CHAN_W-1:0] RESET_VALID_MAX  = 11'd1811;
   localparam logic [CHAN_W-1:0] RESET_DEFAULT    = 11'd992;
   localparam logic [GAP_W-1:0]  RESET_PERIOD     = 16'd14600;

   typedef enum logic [2:0] {
      PH_SYNC,
      PH_LEN,
      PH_TYPE,
      PH_PAYLOAD,
      PH_CRC
   } phase_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_TYPE,
      CSR_VALID_MIN,
      CSR_VALID_MAX,
      CSR_DEFAULT,
      CSR_PERIOD
   } csr_index_type;

   typedef struct packed {
      logic [7:0]        frame_type;
      logic [CHAN_W-1:0] valid_min;
      logic [CHAN_W-1:0] valid_max;
      logic [CHAN_W-1:0] default_value;
      logic [GAP_W-1:0]  period_total;
   } cfg_type;

   typedef struct packed {
      logic                             frame_ok;
      logic [HEAD_DEPTH-1:0][7:0]       head;
   } parse_out_type;

   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

@@ hdl/crsf_channel_frame_decoder_top.sv @@
// A result appears in the cycle after the CRC byte of a good channel frame is transferred.
// Throughput: one byte per cycle; the input stalls only while a held result is itself stalled.
// The single result register sets that limit; the parser updates on every transferred byte.
// Reset: synchronous, active high; clears the parser and the result valid and restores
// all configuration registers to their defaults.
`default_nettype none
`include "crsf_channel_frame_decoder_top_assert.svh"

module crsf_channel_frame_decoder_top
   import crsfd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [7:0]            req_rx_byte,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [CHAN_W-1:0]          rsp_chan_a,
   output logic [CHAN_W-1:0]          rsp_chan_b,
   output logic [CHAN_W-1:0]          rsp_chan_c,
   output logic [CHAN_W-1:0]          rsp_chan_d,
   output logic [CHAN_W-1:0]          rsp_chan_e,
   output logic [GAP_W-1:0]           rsp_frame_gap,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type                             cfg_ff, cfg_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [OUT_CHANNELS-1:0][CHAN_W-1:0] chans_ff;
   logic [GAP_W-1:0]                    gap_ff;
   logic [OUT_CHANNELS-1:0][CHAN_W-1:0] chans_calc;
   logic [GAP_W-1:0]                    gap_calc;
   logic                                byte_take;
   parse_out_type                       parse_out;

   assign csr_ready = 1'b1;
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign byte_take = req_valid && !req_stall;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FRAME_TYPE: cfg_in.frame_type    = csr_wdata[7:0];
            CSR_VALID_MIN:  cfg_in.valid_min     = csr_wdata[CHAN_W-1:0];
            CSR_VALID_MAX:  cfg_in.valid_max     = csr_wdata[CHAN_W-1:0];
            CSR_DEFAULT:    cfg_in.default_value = csr_wdata[CHAN_W-1:0];
            CSR_PERIOD:     cfg_in.period_total  = csr_wdata[GAP_W-1:0];
            default:        cfg_in               = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_type    <= RESET_FRAME_TYPE;
         cfg_ff.valid_min     <= RESET_VALID_MIN;
         cfg_ff.valid_max     <= RESET_VALID_MAX;
         cfg_ff.default_value <= RESET_DEFAULT;
         cfg_ff.period_total  <= RESET_PERIOD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   crsfd_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .byte_take  (byte_take),
      .rx_byte    (req_rx_byte),
      .frame_type (cfg_ff.frame_type),
      .parse_out  (parse_out)
   );

   crsfd_chan_calc u_calc (
      .head      (parse_out.head),
      .cfg       (cfg_ff),
      .chans     (chans_calc),
      .frame_gap (gap_calc)
   );

   // load on a good frame; otherwise hold while stalled, drop once transferred
   always_comb begin
      if (parse_out.frame_ok) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (parse_out.frame_ok) begin
         chans_ff <= chans_calc;
         gap_ff   <= gap_calc;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_chan_a    = chans_ff[0];
   assign rsp_chan_b    = chans_ff[1];
   assign rsp_chan_c    = chans_ff[2];
   assign rsp_chan_d    = chans_ff[3];
   assign rsp_chan_e    = chans_ff[4];
   assign rsp_frame_gap = gap_ff;

   // input stalls only behind a held result
   `CRSFD_CHECK_NOW(a_stall_needs_result, req_stall, rsp_valid_ff)
   // a new result follows a transferred byte
   `CRSFD_CHECK_NOW(a_result_from_byte, $rose(rsp_valid_ff), $past(byte_take))
   // a transferred result with no new frame leaves the register empty
   `CRSFD_CHECK_NEXT(a_result_drains, (rsp_valid_ff && !rsp_stall && !parse_out.frame_ok), !rsp_valid_ff)

endmodule

`default_nettype wire

@@ hdl/crsfd_parser.sv @@
// Byte-level frame parser: sync hunt, length check, head capture, frame type match and CRC-8 check.
// Depends on crsfd_pkg and the assertion macro header.
`default_nettype none
`include "crsf_channel_frame_decoder_top_assert.svh"

module crsfd_parser
   import crsfd_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          byte_take,
   input  wire logic [7:0]    rx_byte,
   input  wire logic [7:0]    frame_type,
   output parse_out_type      parse_out
);

   phase_type                  phase_ff, phase_in;
   logic [LEN_W-1:0]           frame_len_ff, frame_len_in;
   logic [7:0]                 frame_kind_ff, frame_kind_in;
   logic [LEN_W-1:0]           count_ff, count_in;
   logic [7:0]                 crc_ff, crc_in;
   logic [HEAD_DEPTH-1:0][7:0] head_ff, head_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SYNC;
         frame_len_ff  <= '0;
         frame_kind_ff <= '0;
         count_ff      <= '0;
         crc_ff        <= '0;
         head_ff       <= '0;
      end else begin
         phase_ff      <= phase_in;
         frame_len_ff  <= frame_len_in;
         frame_kind_ff <= frame_kind_in;
         count_ff      <= count_in;
         crc_ff        <= crc_in;
         head_ff       <= head_in;
      end
   end

   always_comb begin
      logic [LEN_W-1:0] count_next;
      logic [LEN_W:0]   count_sum;
      count_next         = count_ff + LEN_W'(1);
      count_sum          = {1'b0, count_next} + (LEN_W+1)'(2);
      phase_in           = phase_ff;
      frame_len_in       = frame_len_ff;
      frame_kind_in      = frame_kind_ff;
      count_in           = count_ff;
      crc_in             = crc_ff;
      head_in            = head_ff;
      parse_out.frame_ok = 1'b0;
      parse_out.head     = head_ff;
      if (byte_take) begin
         case (phase_ff)
            PH_SYNC: begin
               if (rx_byte == SYNC_BYTE) begin
                  phase_in = PH_LEN;
               end
            end
            PH_LEN: begin
               // drop back to the hunt on a bad length; this byte is not a sync
               if (rx_byte < 8'd2 || rx_byte > 8'(MAX_FRAME_LEN)) begin
                  phase_in = PH_SYNC;
               end else begin
                  frame_len_in = rx_byte[LEN_W-1:0];
                  phase_in     = PH_TYPE;
               end
            end
            PH_TYPE: begin
               frame_kind_in = rx_byte;
               count_in      = '0;
               head_in       = '0;
               crc_in        = crc8_update(8'h00, rx_byte);
               phase_in      = (frame_len_ff <= LEN_W'(2)) ? PH_CRC : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
               if (count_ff < LEN_W'(HEAD_DEPTH)) begin
                  head_in[count_ff[HEAD_IDX_W-1:0]] = rx_byte;
               end
               crc_in   = crc8_update(crc_ff, rx_byte);
               count_in = count_next;
               if (count_sum >= {1'b0, frame_len_ff}) begin
                  phase_in = PH_CRC;
               end
            end
            PH_CRC: begin
               parse_out.frame_ok = (rx_byte == crc_ff) && (frame_kind_ff == frame_type);
               phase_in           = PH_SYNC;
            end
            default: begin
               phase_in = PH_SYNC;
            end
         endcase
      end
   end

   // a frame in progress always carries a legal length
   `CRSFD_CHECK_NOW(a_len_legal, (phase_ff == PH_TYPE || phase_ff == PH_PAYLOAD || phase_ff == PH_CRC), (frame_len_ff >= LEN_W'(2) && frame_len_ff <= LEN_W'(MAX_FRAME_LEN)))
   // payload phase never runs past the last payload byte
   `CRSFD_CHECK_NOW(a_count_bound, (phase_ff == PH_PAYLOAD), (({1'b0, count_ff} + (LEN_W+1)'(2)) < {1'b0, frame_len_ff}))
   // the CRC byte always ends the frame
   `CRSFD_CHECK_NEXT(a_crc_ends, (byte_take && phase_ff == PH_CRC), (phase_ff == PH_SYNC))

endmodule

`default_nettype wire

@@ hdl/crsfd_chan_calc.sv @@
// Channel unpack, range substitution and frame gap sum for one captured frame head.
// Depends on crsfd_pkg.
`default_nettype none

module crsfd_chan_calc
   import crsfd_pkg::*;
(
   input  wire logic [HEAD_DEPTH-1:0][7:0]     head,
   input  wire cfg_type                        cfg,
   output logic [OUT_CHANNELS-1:0][CHAN_W-1:0] chans,
   output logic [GAP_W-1:0]                    frame_gap
);

   logic [HEAD_DEPTH*8-1:0] word;

   assign word = head;

   always_comb begin
      logic [CHAN_W-1:0] raw;
      logic [GAP_W-1:0]  gap;
      gap = cfg.period_total;
      for (int k = 0; k < OUT_CHANNELS; k++) begin
         if (k < NUM_CHANNELS) begin
            raw = word[k*CHAN_W +: CHAN_W];
            if (raw < cfg.valid_min || raw > cfg.valid_max) begin
               chans[k] = cfg.default_value;
            end else begin
               chans[k] = raw;
            end
            gap = gap - (GAP_W'(cfg.default_value) - GAP_W'(chans[k]));
         end else begin
            raw      = '0;
            chans[k] = cfg.default_value;
         end
      end
      frame_gap = gap;
   end

endmodule

`default_nettype wire
